/* design/fmbre_pkg.sv */
// shared types and codes of the first-match boolean rule engine
package fmbre_pkg;

   // fixed widths of the item fields
   localparam int unsigned WORD_W      = 32;
   localparam int unsigned REQ_W       = 2;
   localparam int unsigned SLOT_W      = 4;
   localparam int unsigned SYM_IDX_W   = 5;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned IDX_MAX_W   = 6;   // enough for the largest rule table
   localparam int unsigned CSR_ADDR_W  = 5;
   localparam int unsigned CSR_SEL_W   = 3;

   // request codes
   localparam logic [REQ_W-1:0] REQ_TICK       = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE_RULE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_SET_SYMBOL = 2'd2;

   // register indexes
   localparam logic [CSR_SEL_W-1:0] REG_SENSOR_MASK   = 3'd0;
   localparam logic [CSR_SEL_W-1:0] REG_TRIGGER_MASK  = 3'd1;
   localparam logic [CSR_SEL_W-1:0] REG_DEFAULT_EN    = 3'd2;
   localparam logic [CSR_SEL_W-1:0] REG_DEFAULT_VALUE = 3'd3;
   localparam logic [CSR_SEL_W-1:0] REG_RULE_COUNT    = 3'd4;

   typedef struct packed {
      logic [WORD_W-1:0]  sensor_mask;
      logic [WORD_W-1:0]  trigger_mask;
      logic [WORD_W-1:0]  default_enable_mask;
      logic [WORD_W-1:0]  default_value_mask;
      logic [COUNT_W-1:0] rule_count;
   } cfg_type;

   typedef struct packed {
      logic [REQ_W-1:0]     req_type;
      logic [SLOT_W-1:0]    rule_index;
      logic [WORD_W-1:0]    cond_care;
      logic [WORD_W-1:0]    cond_value;
      logic [WORD_W-1:0]    act_care;
      logic [WORD_W-1:0]    act_value;
      logic [SYM_IDX_W-1:0] symbol_index;
      logic                 symbol_value;
      logic [WORD_W-1:0]    sensor_values;
   } req_beat_type;

   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] index;
      logic [WORD_W-1:0]    act_care;
      logic [WORD_W-1:0]    act_value;
   } match_type;

endpackage

/* design/first_match_boolean_rule_engine_unit.sv */
// first-match boolean rule engine: input register, rule match and result register
// a beat accepted into the input register is evaluated there, and its result is
// registered into the result register, from which it appears on the rsp channel
// throughput: one beat per cycle while rsp_stall is low; the combinational
// evaluation of the symbol update and the parallel rule compare bound the rate
// reset: synchronous, clears the symbol vector, configuration registers and both valid flags;
// the rule table is not cleared and holds whatever was last written
module first_match_boolean_rule_engine_unit #(
   parameter int unsigned NUM_SYMBOLS = 32,
   parameter int unsigned NUM_RULES   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fmbre_pkg::REQ_W-1:0]         req_type,
   input  logic [fmbre_pkg::SLOT_W-1:0]        req_rule_index,
   input  logic [fmbre_pkg::WORD_W-1:0]        req_cond_care,
   input  logic [fmbre_pkg::WORD_W-1:0]        req_cond_value,
   input  logic [fmbre_pkg::WORD_W-1:0]        req_act_care,
   input  logic [fmbre_pkg::WORD_W-1:0]        req_act_value,
   input  logic [fmbre_pkg::SYM_IDX_W-1:0]     req_symbol_index,
   input  logic                                req_symbol_value,
   input  logic [fmbre_pkg::WORD_W-1:0]        req_sensor_values,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [fmbre_pkg::WORD_W-1:0]        rsp_symbol_bits,
   output logic [fmbre_pkg::WORD_W-1:0]        rsp_trigger_fire,
   output logic                                rsp_rule_fired,
   output logic [fmbre_pkg::SLOT_W-1:0]        rsp_fired_index,
   // configuration port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fmbre_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fmbre_pkg::WORD_W-1:0]        csr_pwdata,
   output logic [fmbre_pkg::WORD_W-1:0]        csr_prdata,
   output logic                                csr_pready
);
   import fmbre_pkg::*;

   cfg_type                cfg;
   match_type              match;

   // input register
   logic                   req_vld_ff;
   req_beat_type           req_ff;
   req_beat_type           req_in;

   // architectural symbol vector
   logic [NUM_SYMBOLS-1:0] sym_ff;
   logic [NUM_SYMBOLS-1:0] sym_in;
   logic [NUM_SYMBOLS-1:0] sensed;
   logic [NUM_SYMBOLS-1:0] restored;

   // result register
   logic                   rsp_vld_ff;
   logic                   rsp_vld_in;
   logic [WORD_W-1:0]      rsp_sym_ff;
   logic [WORD_W-1:0]      rsp_trig_ff;
   logic [WORD_W-1:0]      rsp_trig_in;
   logic                   rsp_fired_ff;
   logic                   rsp_fired_in;
   logic [SLOT_W-1:0]      rsp_idx_ff;
   logic [SLOT_W-1:0]      rsp_idx_in;

   logic                   out_free;
   logic                   advance;
   logic                   req_take;
   logic                   is_tick;

   fmbre_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // handshake: the result register frees when empty or when its beat leaves,
   // and the input register moves into it at that same edge
   assign out_free  = !rsp_vld_ff || !rsp_stall;
   assign advance   = req_vld_ff && out_free;
   assign req_stall = req_vld_ff && !out_free;
   assign req_take  = req_valid && !req_stall;
   assign is_tick   = (req_ff.req_type == REQ_TICK);

   always_comb begin
      req_in.req_type      = req_type;
      req_in.rule_index    = req_rule_index;
      req_in.cond_care     = req_cond_care;
      req_in.cond_value    = req_cond_value;
      req_in.act_care      = req_act_care;
      req_in.act_value     = req_act_value;
      req_in.symbol_index  = req_symbol_index;
      req_in.symbol_value  = req_symbol_value;
      req_in.sensor_values = req_sensor_values;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else if (req_take) begin
         req_vld_ff <= 1'b1;
      end else if (advance) begin
         req_vld_ff <= 1'b0;
      end
   end

   // payload holds while stalled
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   // sensed bits replace the masked symbols before the rules look at them
   assign sensed = (sym_ff & ~cfg.sensor_mask[NUM_SYMBOLS-1:0]) |
                   (req_ff.sensor_values[NUM_SYMBOLS-1:0] &
                    cfg.sensor_mask[NUM_SYMBOLS-1:0]);

   // table writes land at the same edge that retires the write-rule beat
   fmbre_rule_table #(
      .NUM_SYMBOLS (NUM_SYMBOLS),
      .NUM_RULES   (NUM_RULES)
   ) u_rule_table (
      .clock      (clock),
      .wr_en      (advance && (req_ff.req_type == REQ_WRITE_RULE)),
      .wr_beat    (req_ff),
      .sym_in     (sensed),
      .rule_count (cfg.rule_count),
      .match      (match)
   );

   // defaults first, then the fired rule's actions on top
   assign restored = (sensed & ~cfg.default_enable_mask[NUM_SYMBOLS-1:0]) |
                     (cfg.default_value_mask[NUM_SYMBOLS-1:0] &
                      cfg.default_enable_mask[NUM_SYMBOLS-1:0]);

   always_comb begin
      sym_in       = sym_ff;
      rsp_trig_in  = '0;
      rsp_fired_in = 1'b0;
      rsp_idx_in   = '0;
      case (req_ff.req_type)
         REQ_TICK: begin
            sym_in = restored;
            if (match.hit) begin
               sym_in = (restored & ~match.act_care[NUM_SYMBOLS-1:0]) |
                        (match.act_value[NUM_SYMBOLS-1:0] &
                         match.act_care[NUM_SYMBOLS-1:0]);
            end
            rsp_trig_in  = WORD_W'(sym_in) & cfg.trigger_mask;
            rsp_fired_in = match.hit;
            rsp_idx_in   = match.index[SLOT_W-1:0];
         end
         REQ_SET_SYMBOL: begin
            // an index past the last symbol selects nothing
            for (int j = 0; j < NUM_SYMBOLS; j++) begin
               if (32'(req_ff.symbol_index) == j) begin
                  sym_in[j] = req_ff.symbol_value;
               end
            end
         end
         default: sym_in = sym_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
      end else if (advance) begin
         sym_ff <= sym_in;
      end
   end

   assign rsp_vld_in = advance ? 1'b1 : (rsp_stall ? rsp_vld_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_sym_ff   <= WORD_W'(sym_in);
         rsp_trig_ff  <= rsp_trig_in;
         rsp_fired_ff <= rsp_fired_in;
         rsp_idx_ff   <= rsp_idx_in;
      end
   end

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_symbol_bits  = rsp_sym_ff;
   assign rsp_trigger_fire = rsp_trig_ff;
   assign rsp_rule_fired   = rsp_fired_ff;
   assign rsp_fired_index  = rsp_idx_ff;

   // a matched slot always lies below the configured rule count
   assert property (@(posedge clock) disable iff (reset)
      advance && is_tick && match.hit |-> (32'(match.index) < 32'(cfg.rule_count)))
      else $error("matched slot at or above rule count");

   // a non-tick beat reports no trigger and no fired rule
   assert property (@(posedge clock) disable iff (reset)
      advance && !is_tick |=> (rsp_trigger_fire == '0) && !rsp_rule_fired)
      else $error("non-tick beat carries tick status");

   // every beat that retires from the input register shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("retired beat lost before the result register");

   // the symbol vector changes only when a beat retires
   assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(sym_ff))
      else $error("symbol vector changed without a retiring beat");

endmodule

/* design/fmbre_csr.sv */
// configuration register file with apb-style access
module fmbre_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [fmbre_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [fmbre_pkg::WORD_W-1:0]        csr_pwdata,
   output logic [fmbre_pkg::WORD_W-1:0]        csr_prdata,
   output logic                                csr_pready,
   output fmbre_pkg::cfg_type                  cfg
);
   import fmbre_pkg::*;

   cfg_type              cfg_ff;
   cfg_type              cfg_in;
   logic                 wr_en;
   logic [CSR_SEL_W-1:0] sel;

   assign csr_pready = 1'b1;
   assign sel        = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (sel)
            REG_SENSOR_MASK:   cfg_in.sensor_mask         = csr_pwdata;
            REG_TRIGGER_MASK:  cfg_in.trigger_mask        = csr_pwdata;
            REG_DEFAULT_EN:    cfg_in.default_enable_mask = csr_pwdata;
            REG_DEFAULT_VALUE: cfg_in.default_value_mask  = csr_pwdata;
            REG_RULE_COUNT:    cfg_in.rule_count          = csr_pwdata[COUNT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (sel)
         REG_SENSOR_MASK:   csr_prdata = cfg_ff.sensor_mask;
         REG_TRIGGER_MASK:  csr_prdata = cfg_ff.trigger_mask;
         REG_DEFAULT_EN:    csr_prdata = cfg_ff.default_enable_mask;
         REG_DEFAULT_VALUE: csr_prdata = cfg_ff.default_value_mask;
         REG_RULE_COUNT:    csr_prdata = WORD_W'(cfg_ff.rule_count);
         default:           csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* design/fmbre_rule_table.sv */
// rule storage with parallel condition compare and lowest-slot pick
module fmbre_rule_table #(
   parameter int unsigned NUM_SYMBOLS = 32,
   parameter int unsigned NUM_RULES   = 16
) (
   input  logic                               clock,
   input  logic                               wr_en,
   input  fmbre_pkg::req_beat_type            wr_beat,
   input  logic [NUM_SYMBOLS-1:0]             sym_in,
   input  logic [fmbre_pkg::COUNT_W-1:0]      rule_count,
   output fmbre_pkg::match_type               match
);
   import fmbre_pkg::*;

   logic [NUM_SYMBOLS-1:0] cond_care_ff  [NUM_RULES];
   logic [NUM_SYMBOLS-1:0] cond_value_ff [NUM_RULES];
   logic [NUM_SYMBOLS-1:0] act_care_ff   [NUM_RULES];
   logic [NUM_SYMBOLS-1:0] act_value_ff  [NUM_RULES];
   logic [NUM_RULES-1:0]   hit;

   // slots beyond the table are never selected, so such writes drop out
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_RULES; i++) begin
         if (wr_en && (32'(wr_beat.rule_index) == i)) begin
            cond_care_ff[i]  <= wr_beat.cond_care[NUM_SYMBOLS-1:0];
            cond_value_ff[i] <= wr_beat.cond_value[NUM_SYMBOLS-1:0];
            act_care_ff[i]   <= wr_beat.act_care[NUM_SYMBOLS-1:0];
            act_value_ff[i]  <= wr_beat.act_value[NUM_SYMBOLS-1:0];
         end
      end
   end

   // one comparator per slot, only slots below the rule count take part
   always_comb begin
      for (int i = 0; i < NUM_RULES; i++) begin
         hit[i] = (32'(rule_count) > i) &&
                  (((sym_in ^ cond_value_ff[i]) & cond_care_ff[i]) == '0);
      end
   end

   // lowest matching slot wins
   always_comb begin
      match = '0;
      for (int i = NUM_RULES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            match.hit       = 1'b1;
            match.index     = IDX_MAX_W'(i);
            match.act_care  = WORD_W'(act_care_ff[i]);
            match.act_value = WORD_W'(act_value_ff[i]);
         end
      end
   end

endmodule
